FILE: rtl/ttg_pkg.sv
// Shared types, constants and control structs of the tempo tick generator.
`timescale 1ns / 1ps
package ttg_pkg;

    localparam int DEF_MAX_FRAMES   = 4096;
    localparam int DEF_TICKS_PER_QN = 96;
    localparam int DEF_MAX_TICKS    = 64;

    localparam logic [17:0] SAMPLE_RATE_RST = 18'd44100;
    localparam logic [40:0] SUBDIV_RST      = 41'd11453246122;
    localparam logic [5:0]  SECONDS_PER_MIN = 6'd60;
    localparam int          DIV_STEPS       = 64;

    localparam logic signed [63:0] POS_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] POS_MIN = 64'sh8000_0000_0000_0000;
    localparam logic [40:0]        REL_ONES = '1;

    localparam logic [3:0] ADDR_SAMPLE_RATE = 4'h0;
    localparam logic [3:0] ADDR_SUBDIV      = 4'h8;

    typedef struct packed {
        logic               command;
        logic signed [63:0] start_position;
        logic [12:0]        frames;
        logic [25:0]        tempo;
        logic               time_valid;
        logic signed [63:0] time_in_samples;
    } item_word_t;

    typedef struct packed {
        logic        tick_valid;
        logic [11:0] tick_sample;
        logic        last;
        logic        jump_occurred;
        logic        ticks_running;
        logic        truncated;
    } result_word_t;

    typedef enum logic [1:0] {
        DIV_RATE,
        DIV_START,
        DIV_STEP,
        DIV_SAT
    } div_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RATE_GO,
        ST_RATE_WAIT,
        ST_MUL,
        ST_START,
        ST_CATCH,
        ST_MOD0_GO,
        ST_MOD0_WAIT,
        ST_MOD1_GO,
        ST_MOD1_WAIT,
        ST_MOD2_GO,
        ST_MOD2_WAIT,
        ST_STEP,
        ST_FINISH,
        ST_READ,
        ST_OUT
    } ttg_state_t;

    typedef struct packed {
        logic     load;
        logic     div_start;
        logic     div_latch;
        div_sel_t div_sel;
        logic     mul;
        logic     set_start;
        logic     catchup;
        logic     step;
        logic     finish;
        logic     read;
        logic     next_word;
    } ttg_cmd_t;

    typedef struct packed {
        logic div_done;
        logic step_last;
        logic k_last;
    } ttg_status_t;

endpackage

FILE: rtl/ttg_div.sv
// Restoring divider, one quotient bit per cycle, 64-bit dividend by 41-bit divisor.
`timescale 1ns / 1ps
module ttg_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [40:0] divisor,
    output logic        done,
    output logic [63:0] quotient,
    output logic [40:0] remainder
);
    import ttg_pkg::*;

    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [63:0] quo_reg, quo_next;
    logic [40:0] rem_reg, rem_next;
    logic [40:0] dsr_reg, dsr_next;
    logic [41:0] rem_sh;

    always_comb
    begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        rem_sh    = {rem_reg, quo_reg[63]};
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (rem_sh >= {1'b0, dsr_reg})
            begin
                rem_next = 41'(rem_sh - {1'b0, dsr_reg});
                quo_next = {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[40:0];
                quo_next = {quo_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == 7'(DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;
endmodule

FILE: rtl/ttg_datapath.sv
// Datapath: buffer registers, transport state, sample stepper and tick store.
`timescale 1ns / 1ps
module ttg_datapath #(
    parameter int MAX_FRAMES   = ttg_pkg::DEF_MAX_FRAMES,
    parameter int TICKS_PER_QN = ttg_pkg::DEF_TICKS_PER_QN,
    parameter int MAX_TICKS    = ttg_pkg::DEF_MAX_TICKS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [17:0]           sample_rate,
    input  logic [40:0]           subdivision,
    input  ttg_pkg::item_word_t   item,
    input  ttg_pkg::ttg_cmd_t     cmd,
    output ttg_pkg::ttg_status_t  status,
    output ttg_pkg::result_word_t result
);
    import ttg_pkg::*;

    localparam int TW    = $clog2(TICKS_PER_QN + 1);
    localparam int CNT_W = 24 + TW + 1;
    localparam int TOT_W = CNT_W + 2;
    localparam int CW    = $clog2(MAX_TICKS + 1);
    localparam int IW    = (MAX_TICKS > 1) ? $clog2(MAX_TICKS) : 1;
    localparam logic [TW-1:0]    TPQ_V   = TW'(TICKS_PER_QN);
    localparam logic [TOT_W-1:0] MAXT_T  = TOT_W'(MAX_TICKS);
    localparam logic [CW-1:0]    MAXT_C  = CW'(MAX_TICKS);

    // buffer word
    logic               cmd_reg;
    logic signed [63:0] spos_reg;
    logic [12:0]        frames_reg;
    logic [25:0]        tempo_reg;
    logic               tvalid_reg;
    logic [63:0]        tnow_reg;

    // per-buffer work
    logic [44:0]        rate_reg;
    logic [57:0]        prod_reg;
    logic signed [63:0] start_reg;
    logic [40:0]        step_reg, relsat_reg, rel_reg;
    logic signed [65:0] pos_reg;
    logic [12:0]        s_reg;
    logic [TOT_W-1:0]   total_reg;
    logic [CW-1:0]      cc_reg, n_reg, k_reg;
    logic               trunc_reg, jump_reg;
    logic [11:0]        rdata_reg;
    logic [11:0]        tick_mem [MAX_TICKS];

    // transport state
    logic signed [63:0] last_start_reg;
    logic               last_start_known_reg;
    logic signed [63:0] last_abs_reg;
    logic [40:0]        last_rel_reg;
    logic [63:0]        last_time_reg;
    logic               last_time_known_reg;
    logic [12:0]        last_frames_reg;
    logic [25:0]        last_tempo_reg;
    logic               running_reg;

    logic [17:0] sr_eff;
    logic [40:0] sub_eff;
    logic [12:0] frames_sat;
    logic [63:0] div_dividend, start_mag;
    logic [40:0] div_divisor;
    logic        div_done;
    logic [63:0] div_quo;
    logic [40:0] div_rem;

    assign sr_eff     = (sample_rate == '0) ? 18'd1 : sample_rate;
    assign sub_eff    = (subdivision == '0) ? 41'd1 : subdivision;
    assign frames_sat = ({4'b0, item.frames} > 17'(MAX_FRAMES)) ? 13'(MAX_FRAMES) : item.frames;
    assign start_mag  = start_reg[63] ? 64'(-start_reg) : 64'(start_reg);

    always_comb
    begin
        div_dividend = '0;
        div_divisor  = sub_eff;
        unique case (cmd.div_sel)
            DIV_RATE:
            begin
                div_dividend = {14'b0, tempo_reg, 24'b0};
                div_divisor  = {17'b0, 24'(sr_eff * SECONDS_PER_MIN)};
            end
            DIV_START: div_dividend = start_mag;
            DIV_STEP:  div_dividend = {19'b0, rate_reg};
            DIV_SAT:   div_dividend = 64'(POS_MAX);
            default:   div_dividend = '0;
        endcase
    end

    ttg_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // start position and jump test
    logic signed [65:0] int_sum;
    logic signed [63:0] start_v;
    logic               jump_v;
    assign int_sum = 66'(last_start_reg) + $signed({8'b0, prod_reg});
    always_comb
    begin
        if (cmd_reg && last_start_known_reg)
            start_v = (int_sum > 66'(POS_MAX)) ? POS_MAX : int_sum[63:0];
        else
            start_v = spos_reg;
        jump_v = !cmd_reg && tvalid_reg && last_time_known_reg && (last_frames_reg != '0)
              && (tnow_reg != last_time_reg + {51'b0, last_frames_reg})
              && (tnow_reg != last_time_reg);
    end

    // catch-up count
    logic [63:0]         diff;
    logic [24+TW-1:0]    cnt_hi;
    logic [40+TW-1:0]    lo_prod;
    logic [CNT_W-1:0]    cnt_v;
    assign diff    = 64'(start_reg) - 64'(last_abs_reg);
    assign cnt_hi  = (24+TW)'(diff[63:40]) * (24+TW)'(TPQ_V);
    assign lo_prod = (40+TW)'(diff[39:0]) * (40+TW)'(TPQ_V);
    assign cnt_v   = CNT_W'(cnt_hi) + CNT_W'(lo_prod[40+TW-1:40]);

    // sample stepping
    logic               pos_sat;
    logic signed [63:0] pos_v;
    logic [40:0]        rel_use;
    logic [41:0]        rel_sum;
    logic               ahead;
    assign pos_sat = pos_reg > 66'(POS_MAX);
    assign pos_v   = pos_sat ? POS_MAX : pos_reg[63:0];
    assign rel_use = pos_sat ? relsat_reg : rel_reg;
    assign rel_sum = {1'b0, rel_reg} + {1'b0, step_reg};
    assign ahead   = pos_v > last_abs_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmd_reg    <= item.command;
            spos_reg   <= item.start_position;
            frames_reg <= frames_sat;
            tempo_reg  <= item.tempo;
            tvalid_reg <= item.time_valid;
            tnow_reg   <= item.time_in_samples;
        end
        if (cmd.div_latch)
        begin
            unique case (cmd.div_sel)
                DIV_RATE:  rate_reg <= div_quo[44:0];
                DIV_START: rel_reg <= (start_reg[63] && div_rem != '0) ? sub_eff - div_rem
                                                                          : div_rem;
                DIV_STEP:  step_reg <= div_rem;
                DIV_SAT:   relsat_reg <= div_rem;
                default:   rate_reg <= rate_reg;
            endcase
        end
        if (cmd.mul)
            prod_reg <= 58'(frames_reg) * 58'(rate_reg);
        if (cmd.set_start)
        begin
            start_reg <= start_v;
            pos_reg   <= 66'(start_v);
            s_reg     <= '0;
            jump_reg  <= jump_v;
        end
        if (cmd.catchup)
        begin
            if (tempo_reg > last_tempo_reg && start_reg > last_abs_reg)
            begin
                total_reg <= TOT_W'(cnt_v);
                cc_reg    <= (TOT_W'(cnt_v) > MAXT_T) ? MAXT_C : CW'(cnt_v);
            end
            else
            begin
                total_reg <= '0;
                cc_reg    <= '0;
            end
        end
        if (cmd.step && frames_reg != '0)
        begin
            if (ahead && rel_use < last_rel_reg)
            begin
                if (total_reg < MAXT_T)
                    tick_mem[total_reg[IW-1:0]] <= s_reg[11:0];
                total_reg <= total_reg + TOT_W'(1);
            end
            pos_reg <= pos_reg + $signed({21'b0, rate_reg});
            rel_reg <= (rel_sum >= {1'b0, sub_eff}) ? 41'(rel_sum - {1'b0, sub_eff})
                                                    : rel_sum[40:0];
            s_reg   <= s_reg + 13'd1;
        end
        if (cmd.finish)
        begin
            n_reg     <= (total_reg > MAXT_T) ? MAXT_C : CW'(total_reg);
            trunc_reg <= total_reg > MAXT_T;
            k_reg     <= '0;
        end
        if (cmd.read)
            rdata_reg <= tick_mem[k_reg[IW-1:0]];
        if (cmd.next_word)
            k_reg <= k_reg + CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_start_reg       <= '0;
            last_start_known_reg <= 1'b0;
            last_abs_reg         <= POS_MIN;
            last_rel_reg         <= REL_ONES;
            last_time_reg        <= '0;
            last_time_known_reg  <= 1'b0;
            last_frames_reg      <= '0;
            last_tempo_reg       <= '0;
            running_reg          <= 1'b0;
        end
        else
        begin
            if (cmd.set_start)
            begin
                last_start_reg       <= start_v;
                last_start_known_reg <= 1'b1;
                if (jump_v)
                begin
                    // jump: drop the learned position, phase and time; keep the new start and tempo
                    last_abs_reg        <= POS_MIN;
                    last_rel_reg        <= REL_ONES;
                    last_time_reg       <= '0;
                    last_time_known_reg <= 1'b0;
                    last_frames_reg     <= '0;
                    running_reg         <= 1'b0;
                    last_tempo_reg      <= tempo_reg;
                end
                else
                begin
                    if (!cmd_reg && tvalid_reg)
                    begin
                        last_time_reg       <= tnow_reg;
                        last_time_known_reg <= 1'b1;
                        last_frames_reg     <= frames_reg;
                    end
                    if (last_tempo_reg == '0)
                        last_tempo_reg <= tempo_reg;
                end
            end
            if (cmd.step && frames_reg != '0 && ahead)
            begin
                last_rel_reg <= rel_use;
                if (s_reg == frames_reg - 13'd1)
                    last_abs_reg <= pos_v;
            end
            if (cmd.finish)
            begin
                last_tempo_reg <= tempo_reg;
                if (total_reg != '0)
                    running_reg <= 1'b1;
            end
        end
    end

    assign status.div_done  = div_done;
    assign status.step_last = (frames_reg == '0) || (s_reg == frames_reg - 13'd1);
    assign status.k_last    = (n_reg == '0) || (k_reg == n_reg - CW'(1));

    assign result.tick_valid    = n_reg != '0;
    assign result.tick_sample   = (n_reg == '0 || k_reg < cc_reg) ? 12'd0 : rdata_reg;
    assign result.last          = status.k_last;
    assign result.jump_occurred = jump_reg;
    assign result.ticks_running = running_reg;
    assign result.truncated     = trunc_reg;
endmodule

FILE: rtl/ttg_ctrl.sv
// Sequencer for the buffer: divisions, start setup, sample stepping and readout.
`timescale 1ns / 1ps
module ttg_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_stall,
    output logic                 result_valid,
    input  logic                 result_stall,
    input  ttg_pkg::ttg_status_t status,
    output ttg_pkg::ttg_cmd_t    cmd
);
    import ttg_pkg::*;

    ttg_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:      if (item_valid) state_next = ST_RATE_GO;
            ST_RATE_GO:   state_next = ST_RATE_WAIT;
            ST_RATE_WAIT: if (status.div_done) state_next = ST_MUL;
            ST_MUL:       state_next = ST_START;
            ST_START:     state_next = ST_CATCH;
            ST_CATCH:     state_next = ST_MOD0_GO;
            ST_MOD0_GO:   state_next = ST_MOD0_WAIT;
            ST_MOD0_WAIT: if (status.div_done) state_next = ST_MOD1_GO;
            ST_MOD1_GO:   state_next = ST_MOD1_WAIT;
            ST_MOD1_WAIT: if (status.div_done) state_next = ST_MOD2_GO;
            ST_MOD2_GO:   state_next = ST_MOD2_WAIT;
            ST_MOD2_WAIT: if (status.div_done) state_next = ST_STEP;
            ST_STEP:      if (status.step_last) state_next = ST_FINISH;
            ST_FINISH:    state_next = ST_READ;
            ST_READ:      state_next = ST_OUT;
            ST_OUT:
            begin
                if (!result_stall)
                    state_next = status.k_last ? ST_IDLE : ST_READ;
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        cmd.div_sel  = DIV_RATE;
        item_stall   = state_reg != ST_IDLE;
        result_valid = state_reg == ST_OUT;
        unique case (state_reg)
            ST_IDLE:      cmd.load = item_valid;
            ST_RATE_GO:   cmd.div_start = 1'b1;
            ST_RATE_WAIT: cmd.div_latch = status.div_done;
            ST_MUL:       cmd.mul = 1'b1;
            ST_START:     cmd.set_start = 1'b1;
            ST_CATCH:     cmd.catchup = 1'b1;
            ST_MOD0_GO:
            begin
                cmd.div_sel   = DIV_START;
                cmd.div_start = 1'b1;
            end
            ST_MOD0_WAIT:
            begin
                cmd.div_sel   = DIV_START;
                cmd.div_latch = status.div_done;
            end
            ST_MOD1_GO:
            begin
                cmd.div_sel   = DIV_STEP;
                cmd.div_start = 1'b1;
            end
            ST_MOD1_WAIT:
            begin
                cmd.div_sel   = DIV_STEP;
                cmd.div_latch = status.div_done;
            end
            ST_MOD2_GO:
            begin
                cmd.div_sel   = DIV_SAT;
                cmd.div_start = 1'b1;
            end
            ST_MOD2_WAIT:
            begin
                cmd.div_sel   = DIV_SAT;
                cmd.div_latch = status.div_done;
            end
            ST_STEP:      cmd.step = 1'b1;
            ST_FINISH:    cmd.finish = 1'b1;
            ST_READ:      cmd.read = 1'b1;
            ST_OUT:       cmd.next_word = !result_stall;
            default:      cmd.load = 1'b0;
        endcase
    end
endmodule

FILE: rtl/tempo_tick_generator.sv
// Top level of the tempo tick generator: configuration registers and core wiring.
`timescale 1ns / 1ps
// Path: a buffer word passes through four 64-step divisions on the shared divider, then
//   the one-sample-per-cycle stepper over its frames (frames counted as at least 1),
//   then the tick store.
// Input flow: a new buffer word is taken only once the last result word of the previous
//   one has left; results leave through the registered tick store read, held by result_stall.
module tempo_tick_generator #(
    parameter int MAX_FRAMES   = ttg_pkg::DEF_MAX_FRAMES,
    parameter int TICKS_PER_QN = ttg_pkg::DEF_TICKS_PER_QN,
    parameter int MAX_TICKS    = ttg_pkg::DEF_MAX_TICKS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_stall,
    input  ttg_pkg::item_word_t   item,
    output logic                  result_valid,
    input  logic                  result_stall,
    output ttg_pkg::result_word_t result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [3:0]            paddr,
    input  logic [63:0]           pwdata,
    output logic [63:0]           prdata,
    output logic                  pready
);
    import ttg_pkg::*;

    // Reset: asynchronous, active low; clear the sequencer and transport state and
    // load sample_rate 44100 and the default subdivision.
    logic [17:0]  sample_rate_reg;
    logic [40:0]  subdiv_reg;
    logic         cfg_write;
    ttg_cmd_t     cmd;
    ttg_status_t  status;

    // Write on the access phase; decode on the 8-byte slot only.
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_rate_reg <= SAMPLE_RATE_RST;
            subdiv_reg      <= SUBDIV_RST;
        end
        else if (cfg_write)
        begin
            if (paddr[3] == ADDR_SUBDIV[3])
                subdiv_reg <= pwdata[40:0];
            else
                sample_rate_reg <= pwdata[17:0];
        end
    end

    // Return the register selected by the slot.
    assign prdata = (paddr[3] == ADDR_SAMPLE_RATE[3]) ? {46'b0, sample_rate_reg}
                                                      : {23'b0, subdiv_reg};

    // Sequencer: holds the input off while a buffer is worked on.
    ttg_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .status       (status),
        .cmd          (cmd)
    );

    // Datapath: divider, stepper, transport state and tick store.
    ttg_datapath #(
        .MAX_FRAMES   (MAX_FRAMES),
        .TICKS_PER_QN (TICKS_PER_QN),
        .MAX_TICKS    (MAX_TICKS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .sample_rate (sample_rate_reg),
        .subdivision (subdiv_reg),
        .item        (item),
        .cmd         (cmd),
        .status      (status),
        .result      (result)
    );
endmodule

FILE: tb/tb.sv
// Self-checking testbench of the tempo tick generator.
`timescale 1ns / 1ps
module tb;
    import ttg_pkg::*;

    localparam int MAXT     = 64;
    localparam int TPQ      = 96;
    localparam int MAXF     = 4096;
    localparam int LIMIT    = 20000000;
    localparam int N_RANDOM = 110;

    logic         clk;
    logic         rst_n;
    logic         item_valid;
    logic         item_stall;
    item_word_t   item;
    logic         result_valid;
    logic         result_stall;
    result_word_t result;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [3:0]   paddr;
    logic [63:0]  pwdata;
    logic [63:0]  prdata;
    logic         pready;

    tempo_tick_generator dut (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_stall(item_stall), .item(item),
        .result_valid(result_valid), .result_stall(result_stall), .result(result),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Predictor state: mirror of the block's transport memory and registers.
    logic [17:0]        cfg_rate;
    logic [40:0]        cfg_sub;
    logic signed [63:0] tr_start;
    logic               tr_start_known;
    logic signed [63:0] tr_abs;
    logic [40:0]        tr_rel;
    logic [63:0]        tr_time;
    logic               tr_time_known;
    logic [12:0]        tr_frames;
    logic [25:0]        tr_tempo;
    logic               tr_running;

    result_word_t tick_queue[$];
    int  errors;
    int  mismatches;
    longint cycles;
    bit  hold_off;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Watchdog: end the run if the block stops delivering.
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > LIMIT)
            begin
                $display("tb NOT OK");
                $finish;
            end
        end
    end

    function automatic void clear_transport();
        tr_start       = '0;
        tr_start_known = 1'b0;
        tr_abs         = POS_MIN;
        tr_rel         = REL_ONES;
        tr_time        = '0;
        tr_time_known  = 1'b0;
        tr_frames      = '0;
        tr_tempo       = '0;
        tr_running     = 1'b0;
    endfunction

    // Saturating add of a non-negative offset below 2^63.
    function automatic logic signed [63:0] pos_add(logic signed [63:0] a, logic [63:0] b);
        logic [63:0] sum;
        sum = a + b;
        if (!a[63] && sum[63])
            return POS_MAX;
        return sum;
    endfunction

    // Compute the tick words that one buffer causes and queue them.
    function automatic void predict_ticks(item_word_t w);
        logic [11:0]        samples[MAXT];
        logic [63:0]        total;
        logic [63:0]        sr;
        logic [63:0]        sub;
        logic [63:0]        rate;
        logic [63:0]        frames;
        logic signed [63:0] start;
        logic signed [63:0] pos;
        logic signed [63:0] r;
        logic [63:0]        diff;
        logic [63:0]        cnt;
        logic               jump;
        int                 n;
        result_word_t       o;
        total  = 0;
        sr     = (cfg_rate == 0) ? 64'd1 : 64'(cfg_rate);
        sub    = (cfg_sub == 0) ? 64'd1 : 64'(cfg_sub);
        rate   = (64'(w.tempo) << 24) / (sr * 64'd60);
        frames = (w.frames > MAXF) ? 64'(MAXF) : 64'(w.frames);
        start  = w.start_position;
        jump   = 1'b0;
        if (w.command)
        begin
            if (tr_start_known)
                start = pos_add(tr_start, frames * rate);
        end
        else if (w.time_valid)
        begin
            if (tr_time_known && tr_frames != 0 && w.time_in_samples != tr_time + tr_frames
                && w.time_in_samples != tr_time)
                jump = 1'b1;
            tr_time       = w.time_in_samples;
            tr_time_known = 1'b1;
            tr_frames     = frames[12:0];
        end
        if (jump)
            clear_transport();
        tr_start       = start;
        tr_start_known = 1'b1;
        if (tr_tempo == 0)
            tr_tempo = w.tempo;
        // Catch-up ticks land on sample 0 when the tempo rises and the start lies past the last position.
        if (w.tempo > tr_tempo && start > tr_abs)
        begin
            diff = start - tr_abs;
            cnt  = (diff >> 40) * TPQ + (((diff & ((64'd1 << 40) - 1)) * TPQ) >> 40);
            for (int i = 0; i < MAXT; i++)
                if (i < cnt)
                    samples[i] = '0;
            total = cnt;
        end
        for (longint s = 0; s < frames; s++)
        begin
            pos = pos_add(start, s * rate);
            if (pos <= tr_abs)
                continue;
            r = pos % $signed(sub);
            if (r < 0)
                r += $signed(sub);
            if (r[40:0] < tr_rel || r[63:41] != 0)
            begin
                if (total < MAXT)
                    samples[total] = s[11:0];
                total++;
            end
            tr_rel = r[40:0];
        end
        if (frames > 0)
        begin
            pos = pos_add(start, (frames - 1) * rate);
            if (pos > tr_abs)
                tr_abs = pos;
        end
        tr_tempo = w.tempo;
        if (total > 0)
            tr_running = 1'b1;
        n = (total > MAXT) ? MAXT : int'(total);
        if (n == 0)
        begin
            o = '0;
            o.last = 1'b1;
            o.jump_occurred = jump;
            o.ticks_running = tr_running;
            tick_queue = {tick_queue, o};
        end
        for (int k = 0; k < n; k++)
        begin
            o.tick_valid    = 1'b1;
            o.tick_sample   = samples[k];
            o.last          = (k == n - 1);
            o.jump_occurred = jump;
            o.ticks_running = tr_running;
            o.truncated     = (total > MAXT);
            tick_queue = {tick_queue, o};
        end
    endfunction

    // Two-phase register write; the block is idle whenever this runs.
    task automatic write_reg(input logic [3:0] addr, input logic [63:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        if (addr == ADDR_SAMPLE_RATE)
            cfg_rate = data[17:0];
        else
            cfg_sub = data[40:0];
    endtask

    // Offer one word, hold it through stalls, then predict once accepted.
    task automatic send_word(input item_word_t w, input bit gaps);
        int gap;
        gap = 0;
        if (gaps)
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 300) : $urandom_range(0, 3);
        if (gap != 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= w;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        predict_ticks(w);
    endtask

    task automatic drain();
        item_valid <= 1'b0;
        while (tick_queue.size() != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
    endtask

    function automatic item_word_t rand_word(bit wellformed, logic signed [63:0] pos,
                                             logic [63:0] t, int fr);
        item_word_t w;
        w.command         = 1'($urandom_range(0, 1));
        w.start_position  = wellformed ? pos : {$urandom, $urandom};
        w.frames          = fr[12:0];
        w.tempo           = ($urandom_range(0, 3) == 0) ? 26'($urandom) :
                            26'($urandom_range(65536, 240 << 16));
        w.time_valid      = $urandom_range(0, 3) != 0;
        w.time_in_samples = wellformed ? t : {$urandom, $urandom};
        return w;
    endfunction

    // Receiver: random stalls, plus one long hold-off so the block backs up.
    initial
    begin
        int gap;
        result_stall = 1'b1;
        @(posedge rst_n);
        forever
        begin
            if (hold_off)
            begin
                result_stall <= 1'b1;
                repeat (3000) @(posedge clk);
                hold_off = 1'b0;
            end
            gap = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 200) : $urandom_range(0, 2);
            if ($urandom_range(0, 2) == 0)
                gap = 0;
            if (gap != 0)
            begin
                result_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            result_stall <= 1'b0;
            @(posedge clk);
        end
    end

    // Compare every accepted tick word against the oldest prediction.
    always @(posedge clk)
    begin
        result_word_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (tick_queue.size() == 0)
            begin
                errors++;
                if (mismatches++ < 10)
                    $display("unexpected tick word %p", result);
            end
            else
            begin
                want = tick_queue.pop_front();
                if (result !== want)
                begin
                    errors++;
                    if (mismatches++ < 10)
                        $display("tick word mismatch: expected %p got %p", want, result);
                end
            end
        end
    end

    typedef struct {
        item_word_t   w;
        bit           typed;
        result_word_t want;
    } dir_row_t;

    initial
    begin
        dir_row_t           rows[$];
        dir_row_t           row;
        result_word_t       got_first;
        logic signed [63:0] pos;
        logic [63:0]        t;
        int                 fr;
        errors       = 0;
        mismatches   = 0;
        hold_off     = 1'b0;
        rst_n        = 1'b0;
        item_valid   = 1'b0;
        item         = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        cfg_rate     = SAMPLE_RATE_RST;
        cfg_sub      = SUBDIV_RST;
        clear_transport();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table: extremes, both commands, jumps, catch-up, truncation.
        row.typed = 1'b0;
        row.want  = '0;
        row.w = '{1'b0, 64'sd0, 13'd1, 26'd65536, 1'b0, 64'sd0};
        row.typed = 1'b1;
        row.want  = '{1'b1, 12'd0, 1'b1, 1'b0, 1'b1, 1'b0};
        rows = {rows, row};
        row.typed = 1'b0;
        row.w = '{1'b0, 64'sd0, 13'd4096, 26'd67108863, 1'b1, 64'sd100};
        rows = {rows, row};
        row.w = '{1'b0, 64'sd0, 13'd8191, 26'd120 << 16, 1'b1, 64'sd4196};
        rows = {rows, row};
        row.w = '{1'b0, 64'sd0, 13'd0, 26'd120 << 16, 1'b1, 64'sd9999};
        rows = {rows, row};
        row.w = '{1'b1, POS_MAX - 64'sd1000, 13'd256, 26'd200 << 16, 1'b0, 64'sd0};
        rows = {rows, row};
        row.w = '{1'b1, 64'sd0, 13'd512, 26'd60 << 16, 1'b1, -64'sd1};
        rows = {rows, row};
        row.w = '{1'b0, POS_MIN, 13'd128, 26'd0, 1'b1, POS_MIN};
        rows = {rows, row};
        row.w = '{1'b0, -64'sd5 <<< 40, 13'd300, 26'd90 << 16, 1'b1, POS_MAX};
        rows = {rows, row};
        row.w = '{1'b0, 64'sd40 <<< 40, 13'd64, 26'd250 << 16, 1'b1, POS_MAX};
        rows = {rows, row};
        row.w = '{1'b0, 64'sd41 <<< 40, 13'd64, 26'd100 << 16, 1'b1, 64'sd77};
        rows = {rows, row};
        row.w = '{1'b1, 64'sd0, 13'd64, 26'd100 << 16, 1'b0, -64'sd1};
        rows = {rows, row};
        foreach (rows[i])
        begin
            send_word(rows[i].w, 1'b0);
            if (rows[i].typed)
            begin
                got_first = tick_queue[0];
                if (got_first !== rows[i].want)
                begin
                    errors++;
                    $display("directed row %0d predicts %p, table %p", i, got_first,
                             rows[i].want);
                end
            end
        end
        drain();

        // Register extremes, each followed by a short burst.
        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0: begin write_reg(ADDR_SAMPLE_RATE, 64'd8000);
                       write_reg(ADDR_SUBDIV, 64'd1 << 40); end
                1: begin write_reg(ADDR_SAMPLE_RATE, 64'd192000);
                       write_reg(ADDR_SUBDIV, 64'd1); end
                2: begin write_reg(ADDR_SAMPLE_RATE, 64'h3FFFF);
                       write_reg(ADDR_SUBDIV, 64'h1FF_FFFF_FFFF); end
                3: begin write_reg(ADDR_SAMPLE_RATE, 64'd0);
                       write_reg(ADDR_SUBDIV, 64'd0); end
                default: begin write_reg(ADDR_SAMPLE_RATE, 64'd48000);
                       write_reg(ADDR_SUBDIV, 64'd1 << 37); end
            endcase
            pos = $urandom_range(0, 1000) * 64'd1 <<< 30;
            t   = 64'($urandom);
            for (int i = 0; i < 4; i++)
            begin
                fr = $urandom_range(1, 200);
                send_word(rand_word(1'b1, pos, t, fr), 1'b1);
                t += fr;
                pos += 64'(fr) <<< 28;
            end
            drain();
        end

        // Random part: mostly contiguous transport with random tempo and gaps.
        write_reg(ADDR_SAMPLE_RATE, 64'($urandom_range(8000, 192000)));
        write_reg(ADDR_SUBDIV, 64'($urandom_range(1, 1 << 30)) << 8);
        pos = 0;
        t   = 0;
        for (int i = 0; i < N_RANDOM; i++)
        begin
            if (i == 40)
                hold_off = 1'b1;
            fr = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 8191) : $urandom_range(1, 300);
            send_word(rand_word($urandom_range(0, 4) != 0, pos, t, fr), i >= 60);
            if ($urandom_range(0, 9) == 0)
                t = {$urandom, $urandom};
            else
                t += fr;
            pos += 64'(fr) <<< 27;
        end
        drain();
        if (errors == 0 && tick_queue.size() == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end
endmodule
